FILE: src/sidl_pkg.sv
// Shared types and constants for the serial ID list table.
package sidl_pkg;

  localparam int unsigned SERIAL_W = 64;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_GET    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  // Request fields broadcast to every cell while a request runs
  typedef struct packed {
    op_e                 op;
    logic [SERIAL_W-1:0] key;
    logic [INDEX_W-1:0]  index;
  } cmd_t;

  // Token handed from cell to cell
  typedef struct packed {
    logic                hit;
    logic [SERIAL_W-1:0] data;
  } tok_t;

endpackage

FILE: src/sidl_if.sv
// Request and response channel interfaces for the serial ID list table.
interface sidl_req_if import sidl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [SERIAL_W-1:0] serial;
  logic [INDEX_W-1:0]  index;

  modport source (output valid, output op, output serial, output index, input ready);
  modport sink   (input valid, input op, input serial, input index, output ready);
endinterface

interface sidl_rsp_if import sidl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SERIAL_W-1:0] serial_out;
  logic [POS_W-1:0]    position;
  logic [COUNT_W-1:0]  count;
  logic                troubled;

  modport source (output valid, output status, output serial_out, output position,
                  output count, output troubled, input ready);
  modport sink   (input valid, input status, input serial_out, input position,
                  input count, input troubled, output ready);
endinterface

FILE: src/sidl_cell.sv
// One list cell: holds one entry and passes the request token to its neighbor.
module sidl_cell import sidl_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  input  logic [CW-1:0] count_i,
  input  logic          vld_i,
  input  tok_t          tok_i,
  input  logic [CW-1:0] pos_i,
  output logic          vld_o,
  output tok_t          tok_o,
  output logic [CW-1:0] pos_o
);

  logic [SERIAL_W-1:0] entry_q;
  logic                vld_q;
  tok_t                tok_q, tok_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic                here_add, here_get, here_hit;

  // Decode what this cell does for the passing token
  assign here_add = vld_i && (cmd_i.op == OP_ADD) && (int'(count_i) == IDX);
  assign here_get = vld_i && (cmd_i.op == OP_GET) && (int'(cmd_i.index) == IDX);
  assign here_hit = vld_i && (cmd_i.op == OP_SEARCH) && !tok_i.hit &&
                    (int'(count_i) > IDX) && (entry_q == cmd_i.key);

  // Update the token with this cell's contribution
  always_comb begin
    tok_d = tok_i;
    pos_d = pos_i;
    if (here_get) begin
      tok_d.data = entry_q;
    end
    if (here_hit) begin
      tok_d.hit = 1'b1;
      pos_d     = CW'(IDX);
    end
  end

  // Store an appended serial
  always_ff @(posedge clk_i) begin
    if (here_add) begin
      entry_q <= cmd_i.key;
    end
  end

  // Hand the token on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    pos_q <= pos_d;
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;
  assign pos_o = pos_q;

endmodule

FILE: src/serial_id_list_table.sv
// Top level of the serial ID list table: control, count, flag and cell chain.
//
// Use: requests arrive on req_i (op, serial, index) and one response per
// request leaves on rsp_o (status, serial_out, position, count, troubled).
// Op add appends a serial, get reads the entry at an index, search finds
// the lowest matching position, clear drops the count to zero.
// Each request walks a chain of MAX_ENTRIES cells, one cell per cycle, and
// the response is registered once the token leaves the last cell.
// One request is in flight at a time; a new one is taken once the chain is
// empty and the response slot is free or being emptied in the same cycle.
// A stalled receiver holds the response register and blocks new requests.
// Reset clears the count, the trouble flag and all control state; entry
// contents are not cleared and are read only after being written.
module serial_id_list_table import sidl_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sidl_req_if.sink   req_i,
  sidl_rsp_if.source rsp_o
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  state_e              state_q, state_d;
  cmd_t                cmd_q;
  logic                start_q;
  logic [CW-1:0]       count_q, count_d;
  logic                trouble_q, trouble_d;
  logic                out_valid_q, out_valid_d;
  status_e             status_q, status_d;
  logic [SERIAL_W-1:0] sout_q, sout_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                accept, done;

  logic                chain_vld [MAX_ENTRIES+1];
  tok_t                chain_tok [MAX_ENTRIES+1];
  logic [CW-1:0]       chain_pos [MAX_ENTRIES+1];

  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign done        = chain_vld[MAX_ENTRIES];

  // Feed a fresh token into the first cell
  assign chain_vld[0] = start_q;
  assign chain_tok[0] = '{hit: 1'b0, data: '0};
  assign chain_pos[0] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    sidl_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd_q),
      .count_i (count_q),
      .vld_i   (chain_vld[i]),
      .tok_i   (chain_tok[i]),
      .pos_i   (chain_pos[i]),
      .vld_o   (chain_vld[i+1]),
      .tok_o   (chain_tok[i+1]),
      .pos_o   (chain_pos[i+1])
    );
  end

  // Sequence one request through the chain
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_RUN;
      S_RUN:  if (done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Finish the request: update count and flag, build the response
  always_comb begin
    count_d   = count_q;
    trouble_d = trouble_q;
    status_d  = status_q;
    sout_d    = sout_q;
    pos_d     = pos_q;
    if (done) begin
      status_d = ST_OK;
      sout_d   = '0;
      pos_d    = '0;
      unique case (cmd_q.op)
        OP_ADD: begin
          if (count_q == CW'(MAX_ENTRIES)) begin
            trouble_d = 1'b1;
            status_d  = ST_FULL;
          end else begin
            count_d = count_q + CW'(1);
          end
        end
        OP_GET: begin
          if (int'(cmd_q.index) >= int'(count_q)) begin
            status_d = ST_NONE;
          end else begin
            sout_d = chain_tok[MAX_ENTRIES].data;
          end
        end
        OP_SEARCH: begin
          if (chain_tok[MAX_ENTRIES].hit) begin
            pos_d = POS_W'(chain_pos[MAX_ENTRIES]);
          end else begin
            status_d = ST_NONE;
          end
        end
        OP_CLEAR: begin
          count_d = '0;
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  // Hold the response until it is taken
  assign out_valid_d = done || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      count_q     <= '0;
      trouble_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= accept;
      count_q     <= count_d;
      trouble_q   <= trouble_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request and the response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op    <= op_e'(req_i.op);
      cmd_q.key   <= req_i.serial;
      cmd_q.index <= req_i.index;
    end
    status_q <= status_d;
    sout_q   <= sout_d;
    pos_q    <= pos_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.serial_out = sout_q;
  assign rsp_o.position   = pos_q;
  assign rsp_o.count      = COUNT_W'(count_q);
  assign rsp_o.troubled   = trouble_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= MAX_ENTRIES)
    else $error("entry count above capacity");

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (state_q == S_RUN))
    else $error("token left the chain with no request running");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(MAX_ENTRIES + 2) out_valid_q)
    else $error("response not ready after the chain walk");

  a_trouble_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trouble_q |=> trouble_q)
    else $error("trouble flag fell without reset");
`endif

endmodule
